// ===== rtl/core/mec_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Mandelbrot escape colour package
// Widths, fixed-point constants and colour tables shared by the escape unit.
// ----------------------------------------------------------------------------
package mec_pkg;

   localparam int MaxIter  = 20;
   localparam int FracBits = 12;

   // Input point width and the width of the iterated z components.
   localparam int CW     = 16;
   localparam int ZW     = 18;
   localparam int ProdW  = 2 * ZW;
   localparam int SumW   = ProdW + 1;
   localparam int CountW = $clog2(MaxIter + 1);
   localparam int RedW   = 8;
   localparam int GreenW = 6;
   localparam int BlueW  = 8;

   localparam int RedScale = 255;
   localparam int RedDiv   = 20;
   localparam int GreenDiv = 80;

   // |c| limit of 2 in input format, and |z|^2 limit of 4 in product format.
   localparam logic signed [CW-1:0]   CLimit  = CW'(2) <<< FracBits;
   localparam logic signed [SumW-1:0] FourSq  = SumW'(4) <<< (2 * FracBits);

   typedef logic [RedW-1:0]   red_table_type   [2**CountW];
   typedef logic [GreenW-1:0] green_table_type [2**CountW];

   function automatic red_table_type make_red_table();
      red_table_type tab;
      int            v;
      for (int k = 0; k < 2**CountW; k++) begin
         v = (RedScale * k) / RedDiv;
         if (v > 2**RedW - 1) v = 2**RedW - 1;
         tab[k] = RedW'(v);
      end
      return tab;
   endfunction

   function automatic green_table_type make_green_table();
      green_table_type tab;
      int              v;
      for (int k = 0; k < 2**CountW; k++) begin
         v = (RedScale * k) / GreenDiv;
         if (v > 2**GreenW - 1) v = 2**GreenW - 1;
         tab[k] = GreenW'(v);
      end
      return tab;
   endfunction

   localparam red_table_type   RedTable   = make_red_table();
   localparam green_table_type GreenTable = make_green_table();

endpackage
`default_nettype wire

// ===== rtl/core/mandelbrot_escape_colour_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Mandelbrot escape colour unit
// Fully pipelined escape-time colouring of one complex point per clock.
// ----------------------------------------------------------------------------
// Usage: drive req_c_real / req_c_imag (signed, 12 fraction bits) and raise
// start for one cycle per point. busy is always low, so a beat is taken at
// every edge where start is high, one point per clock cycle.
// Each point yields exactly one result beat: rsp_valid is high for one cycle
// with rsp_red, rsp_green and rsp_blue, registered in the colour output
// register at the end of the pipeline; beats leave in the order they came in.
// Each of the 20 iterations is two register stages: a product stage with
// three 18x18 multipliers (x*x, y*y, x*y), then an update stage that forms
// the next z and tests the previous z for escape. An input register, a final
// product stage and the colour output register complete the pipeline.
// The receiver cannot stall, so nothing ever holds the pipeline.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module mandelbrot_escape_colour_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic signed [mec_pkg::CW-1:0]    req_c_real,
   input  wire logic signed [mec_pkg::CW-1:0]    req_c_imag,
   output logic                                  rsp_valid,
   output logic [mec_pkg::RedW-1:0]              rsp_red,
   output logic [mec_pkg::GreenW-1:0]            rsp_green,
   output logic [mec_pkg::BlueW-1:0]             rsp_blue
);

   localparam int N = mec_pkg::MaxIter;

   // z stages: index s holds z_s for s = 0..N.
   logic                                 zv_ff   [N+1];
   logic signed [mec_pkg::ZW-1:0]        zr_ff   [N+1];
   logic signed [mec_pkg::ZW-1:0]        zi_ff   [N+1];
   logic signed [mec_pkg::CW-1:0]        zcr_ff  [N+1];
   logic signed [mec_pkg::CW-1:0]        zci_ff  [N+1];
   logic                                 zdn_ff  [N+1];
   logic [mec_pkg::CountW-1:0]           zcnt_ff [N+1];

   // Product stages: index s holds the squares and the cross product of z_s.
   logic                                 pv_ff   [N+1];
   logic signed [mec_pkg::ProdW-1:0]     pxx_ff  [N+1];
   logic signed [mec_pkg::ProdW-1:0]     pyy_ff  [N+1];
   logic signed [mec_pkg::ProdW-1:0]     pxy_ff  [N+1];
   logic signed [mec_pkg::CW-1:0]        pcr_ff  [N+1];
   logic signed [mec_pkg::CW-1:0]        pci_ff  [N+1];
   logic                                 pdn_ff  [N+1];
   logic [mec_pkg::CountW-1:0]           pcnt_ff [N+1];

   logic                                 in_reject;
   logic signed [mec_pkg::SumW-1:0]      out_sum;
   logic                                 out_escape;
   logic [mec_pkg::CountW-1:0]           out_count_in;
   logic                                 rsp_valid_ff;
   logic [mec_pkg::RedW-1:0]             rsp_red_ff;
   logic [mec_pkg::GreenW-1:0]           rsp_green_ff;

   assign busy = 1'b0;

   // A point with either part beyond magnitude 2 is marked finished with a
   // count of zero, which colours it black.
   assign in_reject = (req_c_real > mec_pkg::CLimit) || (req_c_real < -mec_pkg::CLimit) ||
                      (req_c_imag > mec_pkg::CLimit) || (req_c_imag < -mec_pkg::CLimit);

   always_ff @(posedge clock) begin
      if (reset) begin
         zv_ff[0] <= 1'b0;
      end else begin
         zv_ff[0] <= start;
      end
      zr_ff[0]   <= '0;
      zi_ff[0]   <= '0;
      zcr_ff[0]  <= req_c_real;
      zci_ff[0]  <= req_c_imag;
      zdn_ff[0]  <= in_reject;
      zcnt_ff[0] <= '0;
   end

   for (genvar s = 0; s <= N; s++) begin : g_prod
      always_ff @(posedge clock) begin
         if (reset) begin
            pv_ff[s] <= 1'b0;
         end else begin
            pv_ff[s] <= zv_ff[s];
         end
         pxx_ff[s]  <= zr_ff[s] * zr_ff[s];
         pyy_ff[s]  <= zi_ff[s] * zi_ff[s];
         pxy_ff[s]  <= zr_ff[s] * zi_ff[s];
         pcr_ff[s]  <= zcr_ff[s];
         pci_ff[s]  <= zci_ff[s];
         pdn_ff[s]  <= zdn_ff[s];
         pcnt_ff[s] <= zcnt_ff[s];
      end
   end

   for (genvar s = 0; s < N; s++) begin : g_update
      logic signed [mec_pkg::SumW-1:0]  sum;
      logic signed [mec_pkg::SumW-1:0]  diff;
      logic signed [mec_pkg::ZW-1:0]    re_in;
      logic signed [mec_pkg::ZW-1:0]    im_in;
      logic                             escape;

      // The test on z_s uses the exact squares; the update floors the
      // products back to FracBits fraction bits before adding c.
      assign sum    = {pxx_ff[s][mec_pkg::ProdW-1], pxx_ff[s]} +
                      {pyy_ff[s][mec_pkg::ProdW-1], pyy_ff[s]};
      assign diff   = {pxx_ff[s][mec_pkg::ProdW-1], pxx_ff[s]} -
                      {pyy_ff[s][mec_pkg::ProdW-1], pyy_ff[s]};
      assign escape = sum > mec_pkg::FourSq;
      assign re_in  = diff[mec_pkg::FracBits +: mec_pkg::ZW] +
                      mec_pkg::ZW'(pcr_ff[s]);
      assign im_in  = pxy_ff[s][(mec_pkg::FracBits - 1) +: mec_pkg::ZW] +
                      mec_pkg::ZW'(pci_ff[s]);

      always_ff @(posedge clock) begin
         if (reset) begin
            zv_ff[s+1] <= 1'b0;
         end else begin
            zv_ff[s+1] <= pv_ff[s];
         end
         zr_ff[s+1]  <= re_in;
         zi_ff[s+1]  <= im_in;
         zcr_ff[s+1] <= pcr_ff[s];
         zci_ff[s+1] <= pci_ff[s];
         zdn_ff[s+1] <= pdn_ff[s] || escape;
         if (!pdn_ff[s] && escape) begin
            zcnt_ff[s+1] <= mec_pkg::CountW'(s);
         end else begin
            zcnt_ff[s+1] <= pcnt_ff[s];
         end
      end
   end

   // Final escape test on the last z, then the colour lookup.
   assign out_sum    = {pxx_ff[N][mec_pkg::ProdW-1], pxx_ff[N]} +
                       {pyy_ff[N][mec_pkg::ProdW-1], pyy_ff[N]};
   assign out_escape = out_sum > mec_pkg::FourSq;

   always_comb begin
      if (pdn_ff[N]) begin
         out_count_in = pcnt_ff[N];
      end else if (out_escape) begin
         out_count_in = mec_pkg::CountW'(N);
      end else begin
         out_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pv_ff[N];
      end
      rsp_red_ff   <= mec_pkg::RedTable[out_count_in];
      rsp_green_ff <= mec_pkg::GreenTable[out_count_in];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = '0;

endmodule
`default_nettype wire
